// ----- src/chunked_message_reassembler_macros.svh -----
// Assertion macros shared by the reassembler's modules.
`ifndef CHUNKED_MESSAGE_REASSEMBLER_MACROS_SVH
`define CHUNKED_MESSAGE_REASSEMBLER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define CMR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define CMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cmr_pkg.sv -----
// Shared constants, types and state codes of the chunked message reassembler.
package cmr_pkg;

  // Fixed field layout.
  localparam int CHUNK_BYTES = 7;
  localparam int WORD_BYTES  = 7;
  localparam int HDR_BYTES   = 2;
  localparam int MAX_PAYLOAD = 240;
  localparam int SLOTS       = 2;

  localparam int CH_W     = 2;
  localparam int HDR_W    = 8;
  localparam int SEQ_W    = 7;
  localparam int LEN_W    = 8;
  localparam int WORD_W   = 8 * WORD_BYTES;
  localparam int CHUNK_W  = 8 * CHUNK_BYTES;
  localparam int CNT_W    = 3;
  localparam int OUT_CH_W = 1;

  // Buffer geometry: a channel holds at most MAX_CHUNKS whole chunks.
  localparam int BUF_LEN    = MAX_PAYLOAD + HDR_BYTES + CHUNK_BYTES;
  localparam int MAX_CHUNKS = (BUF_LEN - CHUNK_BYTES) / CHUNK_BYTES + 1;
  localparam int IDX_W      = $clog2(MAX_CHUNKS + 1);
  localparam int RAM_DEPTH  = SLOTS * MAX_CHUNKS;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W     = $clog2(BUF_LEN + (1 << LEN_W) + HDR_BYTES);

  // Stream data widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((HDR_W + CHUNK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((LEN_W + WORD_W + CNT_W + 7) / 8) * 8;

  // Buffer write request from the channel context.
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
  } cmr_wr_req_t;

  // Hand-over of a completed message to the drain sequencer.
  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  plen;
  } cmr_start_t;

  // Drain sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_LO,
    S_LOAD_LO,
    S_READ_HI,
    S_WORD
  } cmr_drain_state_e;

endpackage

// ----- src/chunked_message_reassembler.sv -----
// Top level of the chunked message reassembler.
//
// Input items arrive on the s_axis stream: tuser is the channel, tdata holds
// the header byte (sequence in bits 6:0, last flag in bit 7) and seven data
// bytes. Channels at or above the slot count are dropped without effect.
// Result items leave on m_axis, one per payload word of a delivered message,
// or a single item for an empty payload. deliver_enable is written on the cfg port, one bit per channel.
// Throughput: one chunk per cycle while no message is being drained. Each
// accepted chunk that passes the sequence and space checks is written to the
// chunk buffer in its accept cycle. A completing chunk of an enabled message
// with a valid length starts a drain from the single-port chunk buffer: the
// sequencer reads the first two chunks and loads the first word into the
// output register (an empty payload goes straight to the load), then reads
// one more chunk per further word. s_axis_tready is low during the drain.
// If the receiver stalls, the drain waits on the output register; the final
// word may wait there while new chunks are already accepted.
// Reset clears the channel contexts and the enable bits; buffer contents are
// left as they are and need no clearing pass.
module chunked_message_reassembler
  import cmr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // header, chunk_bytes
  input  logic [CH_W-1:0]       s_axis_tuser,   // channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // payload_length, payload_word, byte_count
  output logic [OUT_CH_W-1:0]   m_axis_tuser,   // out_channel
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [SLOTS-1:0]      cfg_data_i
);

  logic [SLOTS-1:0]   enable_q;
  logic               accept;
  logic               drain_idle;
  cmr_wr_req_t        wr_req;
  cmr_start_t         start;
  logic               rd_re;
  logic [RAM_AW-1:0]  rd_addr;
  logic [RAM_AW-1:0]  ram_addr;
  logic [CHUNK_W-1:0] ram_rdata;

  // Delivery enable register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_valid_i) begin
      enable_q <= cfg_data_i;
    end
  end

  // Chunks are taken only while no drain uses the buffer port.
  assign s_axis_tready = drain_idle;
  assign accept        = s_axis_tvalid & s_axis_tready;

  cmr_ctx u_ctx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .channel_i (s_axis_tuser),
    .header_i  (s_axis_tdata[HDR_W-1:0]),
    .chunk_i   (s_axis_tdata[HDR_W +: CHUNK_W]),
    .enable_i  (enable_q),
    .wr_o      (wr_req),
    .start_o   (start)
  );

  // One buffer port: writes during accept, reads during the drain.
  assign ram_addr = wr_req.we ? wr_req.addr : rd_addr;

  cmr_chunk_ram #(
    .DEPTH (RAM_DEPTH),
    .WIDTH (CHUNK_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_req.we),
    .re_i    (rd_re),
    .addr_i  (ram_addr),
    .wdata_i (s_axis_tdata[HDR_W +: CHUNK_W]),
    .rdata_o (ram_rdata)
  );

  cmr_drain u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .idle_o        (drain_idle),
    .ram_re_o      (rd_re),
    .ram_addr_o    (rd_addr),
    .ram_rdata_i   (ram_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`include "chunked_message_reassembler_macros.svh"

  `CMR_ASSERT(a_port_exclusive, wr_req.we, !rd_re, "buffer write and read in the same cycle")
  `CMR_ASSERT(a_start_when_idle, start.start, drain_idle, "message completed while a drain is running")
  `CMR_ASSERT_NEXT(a_start_leaves_idle, start.start, !drain_idle, "completed message did not start a drain")

endmodule

// ----- src/cmr_chunk_ram.sv -----
// Single-port synchronous chunk buffer with registered read data.
module cmr_chunk_ram #(
  parameter int DEPTH = 70,
  parameter int WIDTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read share the one address; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/cmr_ctx.sv -----
// Per-channel sequence tracking, overflow and length checks for each chunk.
module cmr_ctx
  import cmr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [CH_W-1:0]    channel_i,
  input  logic [HDR_W-1:0]   header_i,
  input  logic [CHUNK_W-1:0] chunk_i,
  input  logic [SLOTS-1:0]   enable_i,
  output cmr_wr_req_t        wr_o,
  output cmr_start_t         start_o
);

  // Channel context: assembling flag, next expected chunk, length prefix.
  logic             asm_q     [SLOTS];
  logic [IDX_W-1:0] nseq_q    [SLOTS];
  logic [LEN_W-1:0] plen_q    [SLOTS];
  logic             plen_bad_q[SLOTS];

  logic              slot_ok;
  logic [SLOT_W-1:0] slot;
  logic [SEQ_W-1:0]  seq;
  logic              last;
  logic              restart;
  logic              asm_eff;
  logic [IDX_W-1:0]  nseq_eff;
  logic              fits;
  logic              chunk_ok;
  logic              asm_d;
  logic [IDX_W-1:0]  nseq_d;
  logic [LEN_W-1:0]  plen_d;
  logic              plen_bad_d;
  logic [LEN_W-1:0]  plen_cur;
  logic              bad_cur;
  logic [FILL_W-1:0] fill_new;
  logic              len_ok;

  // Decode the chunk and check it against the channel's context.
  always_comb begin
    slot_ok    = int'(channel_i) < SLOTS;
    slot       = SLOT_W'(channel_i);
    seq        = header_i[SEQ_W-1:0];
    last       = header_i[HDR_W-1];
    restart    = (seq == '0);
    asm_eff    = restart | asm_q[slot];
    nseq_eff   = restart ? '0 : nseq_q[slot];
    fits       = nseq_eff < IDX_W'(MAX_CHUNKS);
    chunk_ok   = accept_i & slot_ok & asm_eff & fits & (seq == SEQ_W'(nseq_eff));
    asm_d      = chunk_ok & ~last;
    nseq_d     = nseq_eff + IDX_W'(1);
    plen_d     = chunk_i[LEN_W-1:0];
    plen_bad_d = chunk_i[8*HDR_BYTES-1:0] > (8*HDR_BYTES)'(MAX_PAYLOAD);
    plen_cur   = restart ? plen_d : plen_q[slot];
    bad_cur    = restart ? plen_bad_d : plen_bad_q[slot];
    fill_new   = FILL_W'(nseq_d) * FILL_W'(CHUNK_BYTES);
    len_ok     = ~bad_cur & ((FILL_W'(plen_cur) + FILL_W'(HDR_BYTES)) <= fill_new);

    wr_o.we         = chunk_ok;
    wr_o.addr       = RAM_AW'(slot) * RAM_AW'(MAX_CHUNKS) + RAM_AW'(nseq_eff);
    start_o.start   = chunk_ok & last & len_ok & enable_i[slot];
    start_o.slot    = slot;
    start_o.plen    = plen_cur;
  end

  // Control context of the addressed channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) begin
        asm_q[s]  <= 1'b0;
        nseq_q[s] <= '0;
      end
    end else if (accept_i && slot_ok) begin
      asm_q[slot] <= asm_d;
      if (chunk_ok) begin
        nseq_q[slot] <= nseq_d;
      end
    end
  end

  // Length prefix, captured from the first chunk of a message.
  always_ff @(posedge clk_i) begin
    if (chunk_ok && restart) begin
      plen_q[slot]     <= plen_d;
      plen_bad_q[slot] <= plen_bad_d;
    end
  end

endmodule

// ----- src/cmr_drain.sv -----
// Reads a completed message back from the buffer and forms payload words.
module cmr_drain
  import cmr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmr_start_t            start_i,
  output logic                  idle_o,
  output logic                  ram_re_o,
  output logic [RAM_AW-1:0]     ram_addr_o,
  input  logic [CHUNK_W-1:0]    ram_rdata_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // payload_length, payload_word, byte_count
  output logic [OUT_CH_W-1:0]   m_axis_tuser,   // out_channel
  output logic                  m_axis_tlast
);

  localparam int LO_SHIFT = 8 * HDR_BYTES;

  cmr_drain_state_e state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [CHUNK_W-1:0] lo_q, lo_d;

  logic                ovalid_q;
  logic [OUT_CH_W-1:0] o_ch_q;
  logic [LEN_W-1:0]    o_len_q;
  logic [WORD_W-1:0]   o_word_q;
  logic [CNT_W-1:0]    o_cnt_q;
  logic                o_last_q;

  logic [IDX_W-1:0]  rd_idx;
  logic              out_free;
  logic              ld;
  logic [CNT_W-1:0]  cnt;
  logic              word_last;
  logic [WORD_W-1:0] word_raw;
  logic [WORD_W-1:0] word;

  // Word assembly: the payload is offset by the length prefix, so each word
  // takes the top of one chunk and the bottom of the next.
  always_comb begin
    out_free  = ~ovalid_q | m_axis_tready;
    word_last = rem_q <= LEN_W'(WORD_BYTES);
    cnt       = word_last ? rem_q[CNT_W-1:0] : CNT_W'(WORD_BYTES);
    word_raw  = {ram_rdata_i[LO_SHIFT-1:0], lo_q[CHUNK_W-1:LO_SHIFT]};
    for (int i = 0; i < WORD_BYTES; i++) begin
      word[8*i +: 8] = (i < int'(cnt)) ? word_raw[8*i +: 8] : 8'h00;
    end
  end

  // Sequencer: next state, buffer reads and output loads.
  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    plen_d   = plen_q;
    rem_d    = rem_q;
    k_d      = k_q;
    lo_d     = lo_q;
    ld       = 1'b0;
    ram_re_o = 1'b0;
    rd_idx   = (state_q == S_READ_LO) ? k_q : k_q + IDX_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (start_i.start) begin
          slot_d  = start_i.slot;
          plen_d  = start_i.plen;
          rem_d   = start_i.plen;
          k_d     = '0;
          state_d = (start_i.plen == '0) ? S_WORD : S_READ_LO;
        end
      end
      S_READ_LO: begin
        ram_re_o = 1'b1;
        state_d  = S_LOAD_LO;
      end
      S_LOAD_LO: begin
        lo_d     = ram_rdata_i;
        ram_re_o = rd_idx < IDX_W'(MAX_CHUNKS);
        state_d  = S_WORD;
      end
      S_READ_HI: begin
        ram_re_o = rd_idx < IDX_W'(MAX_CHUNKS);
        state_d  = S_WORD;
      end
      S_WORD: begin
        if (out_free) begin
          ld = 1'b1;
          if (word_last) begin
            state_d = S_IDLE;
          end else begin
            lo_d    = ram_rdata_i;
            rem_d   = rem_q - LEN_W'(cnt);
            k_d     = k_q + IDX_W'(1);
            state_d = S_READ_HI;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ram_addr_o = RAM_AW'(slot_q) * RAM_AW'(MAX_CHUNKS) + RAM_AW'(rd_idx);
  assign idle_o     = (state_q == S_IDLE);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Message registers.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    plen_q <= plen_d;
    rem_q  <= rem_d;
    k_q    <= k_d;
    lo_q   <= lo_d;
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ld) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (ld) begin
      o_ch_q   <= OUT_CH_W'(slot_q);
      o_len_q  <= plen_q;
      o_word_q <= word;
      o_cnt_q  <= cnt;
      o_last_q <= word_last;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OUT_DATA_W'({o_cnt_q, o_word_q, o_len_q});
  assign m_axis_tuser  = o_ch_q;
  assign m_axis_tlast  = o_last_q;

`include "chunked_message_reassembler_macros.svh"

  `CMR_ASSERT(a_hi_read_in_range, state_q == S_READ_HI, k_q < IDX_W'(MAX_CHUNKS), "drain index beyond channel buffer")
  `CMR_ASSERT(a_zero_rem_only_empty, state_q == S_WORD && rem_q == '0, plen_q == '0, "word with no bytes left in a non-empty payload")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the chunked message reassembler.
`timescale 1ns / 100ps

module testbench;
  import cmr_pkg::*;

  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 10;
  localparam int DIRECTED_ROWS   = 28;

  // Channel codes as they travel on s_axis_tuser.
  localparam logic [CH_W-1:0] CH_DESC     = 2'd0;
  localparam logic [CH_W-1:0] CH_FRAME    = 2'd1;
  localparam logic [CH_W-1:0] CH_UNKNOWN  = 2'd2;
  localparam logic [CH_W-1:0] CH_RESERVED = 2'd3;

  localparam logic [HDR_W-1:0] LAST_FLAG = 8'h80;

  // One input item and one result item.
  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [HDR_W-1:0]   header;
    logic [CHUNK_W-1:0] bytes;
  } chunk_t;

  typedef struct packed {
    logic [OUT_CH_W-1:0] channel;
    logic [LEN_W-1:0]    length;
    logic [WORD_W-1:0]   word;
    logic [CNT_W-1:0]    count;
    logic                last;
  } payload_word_t;

  typedef chunk_t chunk_queue_t [$];

  // How a row of the directed table is checked, or a register write.
  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_QUIET,
    ROW_TYPED,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    chunk_t        item;
    payload_word_t typed;
  } stim_row_t;

  localparam payload_word_t NO_WORD = '0;

  // Directed table: short messages, drops, the ignored channels and register settings.
  localparam stim_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{ROW_QUIET,  '{CH_DESC,     LAST_FLAG,         56'h00_0000_0000_0000}, NO_WORD},
    '{ROW_CONFIG, '{CH_DESC,     8'h00,             56'h00_0000_0000_0003}, NO_WORD},
    '{ROW_TYPED,  '{CH_DESC,     LAST_FLAG,         56'h00_0000_0000_0000},
                  '{1'b0, 8'd0, 56'h0, 3'd0, 1'b1}},
    '{ROW_TYPED,  '{CH_FRAME,    LAST_FLAG,         56'hEE_DDCC_BBAA_0005},
                  '{1'b1, 8'd5, 56'hEE_DDCC_BBAA, 3'd5, 1'b1}},
    '{ROW_QUIET,  '{CH_FRAME,    LAST_FLAG,         56'hFF_FFFF_FFFF_FFFF}, NO_WORD},
    '{ROW_QUIET,  '{CH_UNKNOWN,  LAST_FLAG,         56'h00_0000_0000_0001}, NO_WORD},
    '{ROW_QUIET,  '{CH_RESERVED, 8'hFF,             56'hFF_FFFF_FFFF_FFFF}, NO_WORD},
    '{ROW_QUIET,  '{CH_DESC,     8'h01,             56'h12_3456_789A_0003}, NO_WORD},
    '{ROW_MODEL,  '{CH_DESC,     8'h00,             56'h11_2233_4455_000C}, NO_WORD},
    '{ROW_MODEL,  '{CH_FRAME,    8'h00,             56'hA1_A2A3_A4A5_0003}, NO_WORD},
    '{ROW_MODEL,  '{CH_DESC,     8'h01,             56'h66_7788_99AA_BBCC}, NO_WORD},
    '{ROW_MODEL,  '{CH_FRAME,    LAST_FLAG | 8'd1,  56'h5A_5A5A_5A5A_5A5A}, NO_WORD},
    '{ROW_MODEL,  '{CH_DESC,     LAST_FLAG | 8'd2,  56'h80_7F01_FE02_FD03}, NO_WORD},
    '{ROW_QUIET,  '{CH_FRAME,    8'h00,             56'h01_0203_0405_0009}, NO_WORD},
    '{ROW_QUIET,  '{CH_FRAME,    8'h02,             56'h0A_0B0C_0D0E_0F10}, NO_WORD},
    '{ROW_QUIET,  '{CH_FRAME,    LAST_FLAG | 8'd1,  56'h21_2223_2425_2627}, NO_WORD},
    '{ROW_QUIET,  '{CH_DESC,     8'h00,             56'h00_0000_0000_0014}, NO_WORD},
    '{ROW_QUIET,  '{CH_DESC,     LAST_FLAG | 8'd1,  56'hCA_FEBA_BEFA_CEDE}, NO_WORD},
    '{ROW_MODEL,  '{CH_DESC,     8'h00,             56'h10_2030_4050_000C}, NO_WORD},
    '{ROW_MODEL,  '{CH_DESC,     LAST_FLAG | 8'd1,  56'h70_8090_A0B0_C0D0}, NO_WORD},
    '{ROW_QUIET,  '{CH_FRAME,    8'h00,             56'h33_3333_3333_0004}, NO_WORD},
    '{ROW_TYPED,  '{CH_FRAME,    LAST_FLAG,         56'h00_0000_BEEF_0002},
                  '{1'b1, 8'd2, 56'hBEEF, 3'd2, 1'b1}},
    '{ROW_CONFIG, '{CH_DESC,     8'h00,             56'h00_0000_0000_0001}, NO_WORD},
    '{ROW_QUIET,  '{CH_FRAME,    LAST_FLAG,         56'h00_0000_0042_0001}, NO_WORD},
    '{ROW_TYPED,  '{CH_DESC,     LAST_FLAG,         56'h55_4433_2211_0005},
                  '{1'b0, 8'd5, 56'h55_4433_2211, 3'd5, 1'b1}},
    '{ROW_CONFIG, '{CH_DESC,     8'h00,             56'h00_0000_0000_0002}, NO_WORD},
    '{ROW_QUIET,  '{CH_DESC,     LAST_FLAG,         56'h00_0000_0000_0000}, NO_WORD},
    '{ROW_TYPED,  '{CH_FRAME,    LAST_FLAG,         56'h00_0000_007F_0001},
                  '{1'b1, 8'd1, 56'h7F, 3'd1, 1'b1}}
  };

  // Delivery settings of the random phases.
  localparam logic [SLOTS-1:0] PHASE_ENABLE [PHASES] = '{2'b11, 2'b00, 2'b01, 2'b10, 2'b11};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // header, chunk_bytes
  logic [CH_W-1:0]       s_axis_tuser  = '0;  // channel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // payload_length, payload_word, byte_count
  logic [OUT_CH_W-1:0]   m_axis_tuser;        // out_channel
  logic                  m_axis_tlast;        // last_word
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [SLOTS-1:0]      cfg_data_i    = '0;

  // Reassembly state as the testbench sees it.
  logic [7:0]       chunk_store  [SLOTS][BUF_LEN];
  int               fill_bytes   [SLOTS] = '{default: 0};
  logic [7:0]       seq_expected [SLOTS] = '{default: 8'd0};
  bit               in_message   [SLOTS] = '{default: 1'b0};
  logic [SLOTS-1:0] deliver_mask = '0;
  payload_word_t    pending_words [$];

  int mismatch_count  = 0;
  int accepted_chunks = 0;
  int quiet_cycles    = 0;
  int stall_left      = 0;
  bit calm            = 1'b0;

  chunked_message_reassembler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock and the single reset pulse.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin : reset_gen
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idle lengths: mostly none or short, now and then long; none at all in a calm phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHUNK_W-1:0] random_bytes();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CHUNK_W-1:0];
  endfunction

  // Appends one chunk to its channel and works out the payload words it releases.
  function automatic void reassemble_chunk(input chunk_t c, input bit record);
    int            slot;
    int            plen;
    int            pos;
    int            cnt;
    int            i;
    logic [6:0]    seq;
    payload_word_t w;
    if (int'(c.channel) >= SLOTS) return;
    slot = int'(c.channel);
    seq  = c.header[SEQ_W-1:0];
    // Sequence zero restarts the channel before anything is checked.
    if (seq == 7'd0) begin
      fill_bytes[slot]   = 0;
      seq_expected[slot] = 8'd0;
      in_message[slot]   = 1'b1;
    end
    if (!in_message[slot] || {1'b0, seq} != seq_expected[slot]) begin
      in_message[slot] = 1'b0;
      return;
    end
    if (fill_bytes[slot] + CHUNK_BYTES > BUF_LEN) begin
      in_message[slot] = 1'b0;
      return;
    end
    for (i = 0; i < CHUNK_BYTES; i++) begin
      chunk_store[slot][fill_bytes[slot] + i] = c.bytes[8*i +: 8];
    end
    fill_bytes[slot]   = fill_bytes[slot] + CHUNK_BYTES;
    seq_expected[slot] = seq_expected[slot] + 8'd1;
    if (!c.header[HDR_W-1]) return;

    // The last chunk closes the message; the length prefix decides delivery.
    in_message[slot] = 1'b0;
    plen = int'({chunk_store[slot][1], chunk_store[slot][0]});
    if (plen > MAX_PAYLOAD || HDR_BYTES + plen > fill_bytes[slot] || !deliver_mask[slot]
        || !record) return;
    w         = '0;
    w.channel = slot[OUT_CH_W-1:0];
    w.length  = plen[LEN_W-1:0];
    if (plen == 0) begin
      w.last = 1'b1;
      pending_words.push_back(w);
      return;
    end
    pos = 0;
    while (pos < plen) begin
      cnt    = (plen - pos > WORD_BYTES) ? WORD_BYTES : plen - pos;
      w.word = '0;
      for (i = 0; i < cnt; i++) begin
        w.word[8*i +: 8] = chunk_store[slot][HDR_BYTES + pos + i];
      end
      pos     = pos + cnt;
      w.count = cnt[CNT_W-1:0];
      w.last  = (pos >= plen);
      pending_words.push_back(w);
    end
  endfunction

  // Random payload length: mostly short, a few near the limit, a few above it.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(200, MAX_PAYLOAD);
    if (r == 1) return ($urandom_range(0, 1) == 0) ? MAX_PAYLOAD + 1
                                                   : $urandom_range(MAX_PAYLOAD + 1, 65535);
    return $urandom_range(0, 30);
  endfunction

  // Chunks of one message in order, optionally with one sequence number spoilt.
  function automatic chunk_queue_t build_message(input logic [CH_W-1:0] ch, input int plen,
                                                 input int n_chunks, input bit corrupt);
    chunk_queue_t msg_q;
    chunk_t       c;
    int           k;
    int           bad_k;
    bad_k = corrupt ? int'($urandom_range(0, n_chunks - 1)) : -1;
    for (k = 0; k < n_chunks; k++) begin
      c.channel = ch;
      c.bytes   = random_bytes();
      if (k == 0) c.bytes[15:0] = plen[15:0];
      c.header  = {k == n_chunks - 1, k[SEQ_W-1:0]};
      if (k == bad_k) begin
        c.header[SEQ_W-1:0] = c.header[SEQ_W-1:0] + SEQ_W'($urandom_range(1, 3));
      end
      msg_q.push_back(c);
    end
    return msg_q;
  endfunction

  // A message that is usually well formed, sometimes short, long or overflowing.
  function automatic chunk_queue_t random_message(input logic [CH_W-1:0] ch);
    int plen;
    int needed;
    int n;
    int r;
    plen   = pick_length();
    needed = (plen + HDR_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    r      = $urandom_range(0, 15);
    if (plen > MAX_PAYLOAD) n = $urandom_range(1, 4);
    else if (r == 0 && needed > 1) n = needed - 1;
    else if (r == 1) n = needed + $urandom_range(1, 2);
    else if (r == 2 && $urandom_range(0, 3) == 0) n = MAX_CHUNKS + 1;
    else n = needed;
    return build_message(ch, plen, n, $urandom_range(0, 9) == 0);
  endfunction

  // Offers one item after a random gap and records what it should release.
  task automatic send_item(input chunk_t c, input row_kind_e kind, input payload_word_t typed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.bytes, c.header};
    s_axis_tuser  <= c.channel;
    do @(posedge clk_i); while (!s_axis_tready);
    reassemble_chunk(c, kind == ROW_MODEL);
    if (kind == ROW_TYPED) pending_words.push_back(typed);
    if (int'(c.channel) < SLOTS) accepted_chunks++;
  endtask

  // Merges two channels' messages in random order, each kept in sequence.
  task automatic send_interleaved(input chunk_queue_t desc_q, input chunk_queue_t frame_q);
    chunk_t c;
    while (desc_q.size() != 0 || frame_q.size() != 0) begin
      if (frame_q.size() == 0 || (desc_q.size() != 0 && $urandom_range(0, 1) == 0))
        c = desc_q.pop_front();
      else
        c = frame_q.pop_front();
      send_item(c, ROW_MODEL, NO_WORD);
    end
  endtask

  // Holds the sender until every expected word is out and a silent drain has had time.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic [SLOTS-1:0] value);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    deliver_mask = value;
  endtask

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: random stalls on m_axis_tready.
  always @(posedge clk_i) begin : result_sink
    int gap;
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    = stall_left - 1;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      m_axis_tready <= (gap == 0);
      stall_left    = (gap > 0) ? gap - 1 : 0;
    end
  end

  // Each accepted result against the oldest expected word.
  always @(posedge clk_i) begin : result_check
    payload_word_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $error("Result with no expectation waiting: tdata %0h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("out_channel", WORD_W'(want.channel), WORD_W'(m_axis_tuser));
        check_field("payload_length", WORD_W'(want.length), WORD_W'(m_axis_tdata[LEN_W-1:0]));
        check_field("payload_word", want.word, m_axis_tdata[LEN_W +: WORD_W]);
        check_field("byte_count", WORD_W'(want.count),
                    WORD_W'(m_axis_tdata[LEN_W + WORD_W +: CNT_W]));
        check_field("last_word", WORD_W'(want.last), WORD_W'(m_axis_tlast));
      end
    end
  end

  // Watchdog: too long without any item moving on any channel ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int           row;
    int           phase;
    int           goal;
    int           r;
    chunk_queue_t desc_q;
    chunk_queue_t frame_q;
    chunk_t       noise;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed table, starting with delivery disabled as after reset.
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      if (DIRECTED_TABLE[row].kind == ROW_CONFIG)
        write_enable(DIRECTED_TABLE[row].item.bytes[SLOTS-1:0]);
      else
        send_item(DIRECTED_TABLE[row].item, DIRECTED_TABLE[row].kind,
                  DIRECTED_TABLE[row].typed);
    end

    // Full buffer: the longest payload beside a length one above the limit, then an overflow.
    write_enable(2'b11);
    desc_q  = build_message(CH_DESC, MAX_PAYLOAD, MAX_CHUNKS, 1'b0);
    frame_q = build_message(CH_FRAME, MAX_PAYLOAD + 1, MAX_CHUNKS, 1'b0);
    send_interleaved(desc_q, frame_q);
    desc_q  = build_message(CH_DESC, 5, MAX_CHUNKS + 1, 1'b0);
    frame_q = {};
    send_interleaved(desc_q, frame_q);

    // Random phases, each under its own delivery setting.
    for (phase = 0; phase < PHASES; phase++) begin
      write_enable(PHASE_ENABLE[phase]);
      calm = (phase == 2);
      goal = accepted_chunks + ITEMS_PER_PHASE;
      while (accepted_chunks < goal) begin
        r = $urandom_range(0, 19);
        if (r < 14) begin
          desc_q  = random_message(CH_DESC);
          frame_q = random_message(CH_FRAME);
          if (r >= 6) begin
            if ($urandom_range(0, 1) == 0) desc_q = {};
            else frame_q = {};
          end
          send_interleaved(desc_q, frame_q);
        end else if (r < 19) begin
          noise.channel = CH_W'($urandom_range(0, 3));
          noise.header  = HDR_W'($urandom_range(0, 255));
          noise.bytes   = random_bytes();
          send_item(noise, ROW_MODEL, NO_WORD);
        end else begin
          settle_idle();
        end
      end
    end
    calm = 1'b0;

    settle_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- chunked_message_reassembler.f -----
+incdir+src
src/cmr_pkg.sv
src/cmr_chunk_ram.sv
src/cmr_ctx.sv
src/cmr_drain.sv
src/chunked_message_reassembler.sv
sim/testbench.sv
